// File: hw/rtl/obp_pkg.sv
// Shared constants, codes and types for the online bin packing placer.
// No dependencies; used by obp_ram users and the top level by scoped names.
`default_nettype none

package obp_pkg;

    localparam int MAX_BINS      = 256;
    localparam int FRACTION_BITS = 16;

    localparam int SIZE_W      = 17;
    localparam int IDX_W       = $clog2(MAX_BINS);
    localparam int CNT_W       = $clog2(MAX_BINS + 1);
    localparam int BIN_INDEX_W = 8;
    localparam int BINS_USED_W = 9;
    localparam int STATUS_W    = 2;
    localparam int MODE_W      = 2;
    localparam int CFG_INDEX_W = 2;

    localparam logic [SIZE_W-1:0] SIZE_MAX = {SIZE_W{1'b1}};
    localparam logic [SIZE_W-1:0] CAP_RESET =
        (FRACTION_BITS >= SIZE_W) ? SIZE_MAX : SIZE_W'(64'd1 << FRACTION_BITS);

    localparam logic [CNT_W-1:0] BIN_LIMIT = CNT_W'(MAX_BINS);

    // Placement rules
    localparam logic [MODE_W-1:0] MODE_NEXT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FIRST = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BEST  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_EXISTING = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NEW      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVERSIZE = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_MODE     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CAPACITY = 2'd1;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DECIDE = 4'b0100,
        S_EMIT   = 4'b1000
    } state_t;

endpackage

`default_nettype wire

// File: hw/rtl/obp_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module obp_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/online_bin_packing_placer.sv
// Online bin packing placer: top level with the placement sequencer.
// Depends on obp_pkg and obp_ram (bin room table).
//
// Usage:
//   Input channel (in_valid / in_stall) carries item_size and first_item.
//   Output channel (out_valid / out_stall) carries bin_index, bins_used and
//   status, one result beat for every input beat, in order.
//   Configuration: cfg_write with cfg_index and cfg_data; index 0 sets
//   placement_mode, index 1 sets bin_capacity. Write only while idle.
//   One item is worked on at a time. With n open bins (after any first_item
//   clear) the room table is read one entry per cycle, up to n entries,
//   through the single RAM read port; then the DECIDE state writes the room
//   of the chosen or new bin and the EMIT state loads the output register.
//   Next fit reads only one entry; first fit stops at the first bin that
//   fits; an oversize item skips the table and the DECIDE state, an empty
//   table skips only the table.
//   Reset empties the table (bin count zero), sets first fit and a capacity
//   of 1.0; the room memory itself is not cleared.
//   A stalled result holds in the output register; the next item may be
//   accepted meanwhile but its result waits until the register frees.
`default_nettype none

module online_bin_packing_placer (
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    input  wire logic                                cfg_write,
    input  wire logic [obp_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [obp_pkg::SIZE_W-1:0]          cfg_data,

    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [obp_pkg::SIZE_W-1:0]          item_size,
    input  wire logic                                first_item,

    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic      [obp_pkg::BIN_INDEX_W-1:0]     bin_index,
    output logic      [obp_pkg::BINS_USED_W-1:0]     bins_used,
    output logic      [obp_pkg::STATUS_W-1:0]        status
);

    localparam int SIZE_W = obp_pkg::SIZE_W;
    localparam int IDX_W  = obp_pkg::IDX_W;
    localparam int CNT_W  = obp_pkg::CNT_W;

    // Control state
    obp_pkg::state_t                state_reg, state_next;
    logic [obp_pkg::MODE_W-1:0]     mode_reg, mode_next;
    logic [SIZE_W-1:0]              cap_reg, cap_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    logic [CNT_W-1:0]               issue_reg, issue_next;
    logic                           chk_valid_reg, chk_valid_next;
    logic                           found_reg, found_next;
    logic                           out_valid_reg, out_valid_next;

    // Payload
    logic [SIZE_W-1:0]              size_reg, size_next;
    logic [IDX_W-1:0]               chk_addr_reg, chk_addr_next;
    logic [IDX_W-1:0]               best_idx_reg, best_idx_next;
    logic [SIZE_W-1:0]              best_room_reg, best_room_next;
    logic [IDX_W-1:0]               res_idx_reg, res_idx_next;
    logic [CNT_W-1:0]               res_used_reg, res_used_next;
    logic [obp_pkg::STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [IDX_W-1:0]               out_idx_reg, out_idx_next;
    logic [CNT_W-1:0]               out_used_reg, out_used_next;
    logic [obp_pkg::STATUS_W-1:0]   out_status_reg, out_status_next;

    // Room table ports
    logic                           ram_wr_en;
    logic [IDX_W-1:0]               ram_wr_addr;
    logic [SIZE_W-1:0]              ram_wr_data;
    logic                           ram_rd_en;
    logic [SIZE_W-1:0]              ram_rd_data;

    logic                           in_take;
    logic [CNT_W-1:0]               count_start;
    logic                           best_mode;
    logic                           fit;
    logic                           better;

    obp_ram #(
        .WIDTH (SIZE_W),
        .DEPTH (obp_pkg::MAX_BINS)
    ) u_room (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (issue_reg[IDX_W-1:0]),
        .rd_data (ram_rd_data)
    );

    assign in_stall  = (state_reg != obp_pkg::S_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign bin_index = obp_pkg::BIN_INDEX_W'(out_idx_reg);
    assign bins_used = obp_pkg::BINS_USED_W'(out_used_reg);
    assign status    = out_status_reg;

    assign count_start = first_item ? '0 : count_reg;
    assign best_mode   = (mode_reg == obp_pkg::MODE_BEST);
    assign fit         = chk_valid_reg && (size_reg <= ram_rd_data);
    assign better      = !found_reg || (ram_rd_data < best_room_reg);

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        cap_next        = cap_reg;
        count_next      = count_reg;
        issue_next      = issue_reg;
        chk_valid_next  = 1'b0;
        found_next      = found_reg;
        out_valid_next  = out_valid_reg && out_stall;
        size_next       = size_reg;
        chk_addr_next   = chk_addr_reg;
        best_idx_next   = best_idx_reg;
        best_room_next  = best_room_reg;
        res_idx_next    = res_idx_reg;
        res_used_next   = res_used_reg;
        res_status_next = res_status_reg;
        out_idx_next    = out_idx_reg;
        out_used_next   = out_used_reg;
        out_status_next = out_status_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = best_idx_reg;
        ram_wr_data     = best_room_reg - size_reg;
        ram_rd_en       = 1'b0;

        if (cfg_write)
        begin
            case (cfg_index)
                obp_pkg::REG_MODE:     mode_next = cfg_data[obp_pkg::MODE_W-1:0];
                obp_pkg::REG_CAPACITY: cap_next  = cfg_data;
                default:               ;
            endcase
        end

        unique case (state_reg)
            obp_pkg::S_IDLE:
            begin
                if (in_take)
                begin
                    size_next  = item_size;
                    count_next = count_start;
                    found_next = 1'b0;
                    if (item_size > cap_reg)
                    begin
                        res_idx_next    = '0;
                        res_used_next   = count_start;
                        res_status_next = obp_pkg::ST_OVERSIZE;
                        state_next      = obp_pkg::S_EMIT;
                    end
                    else if (count_start == '0)
                    begin
                        state_next = obp_pkg::S_DECIDE;
                    end
                    else
                    begin
                        // next fit looks only at the newest bin
                        issue_next = (mode_reg == obp_pkg::MODE_NEXT) ?
                                     count_start - 1'b1 : '0;
                        state_next = obp_pkg::S_SCAN;
                    end
                end
            end

            obp_pkg::S_SCAN:
            begin
                // issue one read a cycle, check the entry read last cycle
                if (issue_reg != count_reg)
                begin
                    ram_rd_en      = 1'b1;
                    chk_valid_next = 1'b1;
                    chk_addr_next  = issue_reg[IDX_W-1:0];
                    issue_next     = issue_reg + 1'b1;
                end
                if (fit && (!best_mode || better))
                begin
                    found_next     = 1'b1;
                    best_idx_next  = chk_addr_reg;
                    best_room_next = ram_rd_data;
                end
                if ((fit && !best_mode) || (issue_reg == count_reg))
                begin
                    chk_valid_next = 1'b0;
                    state_next     = obp_pkg::S_DECIDE;
                end
            end

            obp_pkg::S_DECIDE:
            begin
                if (found_reg)
                begin
                    ram_wr_en       = 1'b1;
                    res_idx_next    = best_idx_reg;
                    res_used_next   = count_reg;
                    res_status_next = obp_pkg::ST_EXISTING;
                end
                else if (count_reg == obp_pkg::BIN_LIMIT)
                begin
                    res_idx_next    = '0;
                    res_used_next   = count_reg;
                    res_status_next = obp_pkg::ST_FULL;
                end
                else
                begin
                    // open a new bin at the end of the table
                    ram_wr_en       = 1'b1;
                    ram_wr_addr     = count_reg[IDX_W-1:0];
                    ram_wr_data     = cap_reg - size_reg;
                    count_next      = count_reg + 1'b1;
                    res_idx_next    = count_reg[IDX_W-1:0];
                    res_used_next   = count_reg + 1'b1;
                    res_status_next = obp_pkg::ST_NEW;
                end
                state_next = obp_pkg::S_EMIT;
            end

            obp_pkg::S_EMIT:
            begin
                // hold until the output register frees
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_idx_next    = res_idx_reg;
                    out_used_next   = res_used_reg;
                    out_status_next = res_status_reg;
                    state_next      = obp_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = obp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= obp_pkg::S_IDLE;
            mode_reg      <= obp_pkg::MODE_FIRST;
            cap_reg       <= obp_pkg::CAP_RESET;
            count_reg     <= '0;
            issue_reg     <= '0;
            chk_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            cap_reg       <= cap_next;
            count_reg     <= count_next;
            issue_reg     <= issue_next;
            chk_valid_reg <= chk_valid_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg       <= size_next;
        chk_addr_reg   <= chk_addr_next;
        best_idx_reg   <= best_idx_next;
        best_room_reg  <= best_room_next;
        res_idx_reg    <= res_idx_next;
        res_used_reg   <= res_used_next;
        res_status_reg <= res_status_next;
        out_idx_reg    <= out_idx_next;
        out_used_reg   <= out_used_next;
        out_status_reg <= out_status_next;
    end

endmodule

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for online_bin_packing_placer: directed and random item streams
// checked against a bin room predictor kept in a small scoreboard class.
// Depends on obp_pkg and the placer RTL; reads no files.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import obp_pkg::*;

    localparam logic [MODE_W-1:0]      MODE_SPARE  = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE   = 2'd2;
    localparam int                     RANDOM_GOAL = 1450;
    localparam int                     LONG_HOLD   = 400;
    localparam int                     TAIL_CYCLES = 300;

    class bin_ledger;
        logic [SIZE_W-1:0] room [MAX_BINS];
        int                open_bins;
        logic [MODE_W-1:0] mode;
        logic [SIZE_W-1:0] capacity;
        logic [BIN_INDEX_W+BINS_USED_W+STATUS_W-1:0] awaiting [$];
        int                errors;
        int                seen [4];

        function new();
            open_bins = 0;
            mode      = MODE_FIRST;
            capacity  = CAP_RESET;
            errors    = 0;
            foreach (seen[i]) seen[i] = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [SIZE_W-1:0] data);
            if (idx == REG_MODE)
                mode = data[MODE_W-1:0];
            else if (idx == REG_CAPACITY)
                capacity = data;
        endfunction

        // Bin that takes the item under the current rule, or -1 when none has room
        function int choose_bin(logic [SIZE_W-1:0] size);
            int pick;
            pick = -1;
            if (open_bins == 0)
                return -1;
            if (mode == MODE_NEXT)
                return (size <= room[open_bins-1]) ? open_bins - 1 : -1;
            for (int b = 0; b < open_bins; b++) begin
                if (size <= room[b]) begin
                    if (mode != MODE_BEST)
                        return b;
                    if (pick < 0 || room[b] < room[pick])
                        pick = b;
                end
            end
            return pick;
        endfunction

        function void note_item(logic [SIZE_W-1:0] size, logic first);
            logic [BIN_INDEX_W-1:0] idx;
            logic [STATUS_W-1:0]    st;
            int                     slot;
            if (first)
                open_bins = 0;
            idx = '0;
            if (size > capacity) begin
                st = ST_OVERSIZE;
            end
            else begin
                slot = choose_bin(size);
                if (slot >= 0) begin
                    room[slot] = room[slot] - size;
                    idx = BIN_INDEX_W'(slot);
                    st = ST_EXISTING;
                end
                else if (open_bins >= MAX_BINS) begin
                    st = ST_FULL;
                end
                else begin
                    room[open_bins] = capacity - size;
                    idx = BIN_INDEX_W'(open_bins);
                    open_bins++;
                    st = ST_NEW;
                end
            end
            awaiting.push_back({idx, BINS_USED_W'(open_bins), st});
        endfunction

        function void check_placement(logic [BIN_INDEX_W-1:0] idx,
                                      logic [BINS_USED_W-1:0] used,
                                      logic [STATUS_W-1:0]    st);
            logic [BIN_INDEX_W-1:0] want_idx;
            logic [BINS_USED_W-1:0] want_used;
            logic [STATUS_W-1:0]    want_st;
            if (awaiting.size() == 0) begin
                $error("result beat with no item outstanding: bin_index %0d bins_used %0d status %0d",
                       idx, used, st);
                errors++;
                return;
            end
            {want_idx, want_used, want_st} = awaiting.pop_front();
            seen[want_st]++;
            if (idx !== want_idx) begin
                $error("bin_index: expected %0d, got %0d", want_idx, idx);
                errors++;
            end
            if (used !== want_used) begin
                $error("bins_used: expected %0d, got %0d", want_used, used);
                errors++;
            end
            if (st !== want_st) begin
                $error("status: expected %0d, got %0d", want_st, st);
                errors++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [SIZE_W-1:0]      cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [SIZE_W-1:0]      item_size;
    logic                   first_item;
    logic                   out_valid;
    logic                   out_stall;
    logic [BIN_INDEX_W-1:0] bin_index;
    logic [BINS_USED_W-1:0] bins_used;
    logic [STATUS_W-1:0]    status;

    bin_ledger ledger = new();
    int        items_sent = 0;
    int        burst_left = 0;
    int        settings_used = 0;
    int        holds_done = 0;
    bit        hold_request = 0;
    bit        holding = 0;

    online_bin_packing_placer uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .item_size  (item_size),
        .first_item (first_item),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .bin_index  (bin_index),
        .bins_used  (bins_used),
        .status     (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            ledger.check_placement(bin_index, bins_used, status);
    end

    // Receiver: stall segments of varying style, plus long hold-offs on request
    initial
    begin
        int style;
        int span;
        int period;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request) begin
                hold_request = 0;
                holding = 1;
                for (int k = 0; k < LONG_HOLD; k++) begin
                    @(negedge clk);
                    out_stall <= 1'b1;
                end
                holding = 0;
                holds_done++;
            end
            style  = $urandom_range(0, 3);
            span   = $urandom_range(20, 200);
            period = $urandom_range(2, 7);
            for (int k = 0; k < span; k++) begin
                @(negedge clk);
                case (style)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 9) < 3);
                    2:       out_stall <= (k % period == 0);
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [SIZE_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        ledger.write_reg(idx, data);
    endtask

    // Offer one beat; bursts of random length separated by random gaps
    task automatic offer(input logic [SIZE_W-1:0] size, input logic first);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 7))
                0, 1:    gap = 0;
                2:       gap = $urandom_range(20, 60);
                default: gap = $urandom_range(1, 6);
            endcase
            if (gap > 0) begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid   <= 1'b1;
        item_size  <= size;
        first_item <= first;
        do @(posedge clk); while (in_stall);
        ledger.note_item(size, first);
        items_sent++;
    endtask

    // Drop valid and let every outstanding result drain before touching registers
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (ledger.awaiting.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [SIZE_W-1:0] pick_size(logic [SIZE_W-1:0] cap);
        int c;
        int roll;
        c = int'(cap);
        roll = $urandom_range(0, 19);
        if (roll < 10)
            return SIZE_W'($urandom_range(0, c >> $urandom_range(0, 5)));
        else if (roll < 12)
            return cap;
        else if (roll < 13)
            return '0;
        else if (roll < 16)
            return (c < SIZE_MAX) ? SIZE_W'($urandom_range(c + 1, SIZE_MAX)) : cap;
        return SIZE_W'($urandom_range(0, SIZE_MAX));
    endfunction

    // Open every bin with items too big to share, overflow it, then scan it whole
    task automatic fill_table(input logic [MODE_W-1:0] rule, input logic [SIZE_W-1:0] cap);
        int lo;
        set_reg(REG_MODE, SIZE_W'(rule));
        set_reg(REG_CAPACITY, cap);
        lo = (int'(cap) >> 1) + 1;
        for (int k = 0; k < MAX_BINS + 4; k++)
            offer(SIZE_W'($urandom_range(lo, cap)), k == 0);
        offer('0, 1'b0);
        settle();
        set_reg(REG_MODE, SIZE_W'(MODE_FIRST));
        for (int k = 0; k < 3; k++)
            offer(SIZE_W'($urandom_range(lo, cap)), 1'b0);
        offer('0, 1'b0);
    endtask

    initial
    begin
        int goal;
        int phase;
        int runs;
        int span;
        logic [SIZE_W-1:0] cap;
        rst_n      = 1'b0;
        cfg_write  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        item_size  = '0;
        first_item = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset rule is first fit at a capacity of 1.0
        offer('0, 1'b1);
        offer(SIZE_W'(65536), 1'b0);
        offer('0, 1'b0);
        offer(SIZE_W'(65537), 1'b0);
        offer(SIZE_MAX, 1'b0);
        offer(SIZE_MAX, 1'b1);
        offer(SIZE_W'(1), 1'b0);
        offer(SIZE_W'(40000), 1'b0);
        offer(SIZE_W'(30000), 1'b0);
        offer(SIZE_W'(20000), 1'b0);
        settle();
        set_reg(REG_MODE, SIZE_W'(MODE_BEST));
        offer(SIZE_W'(5000), 1'b0);
        offer(SIZE_W'(5535), 1'b0);
        offer('0, 1'b0);
        settle();
        // next fit starting from an empty table
        set_reg(REG_MODE, SIZE_W'(MODE_NEXT));
        offer(SIZE_W'(10), 1'b1);
        offer(SIZE_W'(65526), 1'b0);
        offer(SIZE_W'(1), 1'b0);
        offer(SIZE_W'(65535), 1'b0);
        settle();
        // spare rule code with a capacity change over live bins
        set_reg(REG_MODE, SIZE_W'(MODE_SPARE));
        set_reg(REG_CAPACITY, SIZE_W'(100));
        offer(SIZE_W'(100), 1'b0);
        offer(SIZE_W'(101), 1'b0);
        settle();
        set_reg(REG_CAPACITY, '0);
        set_reg(REG_SPARE, SIZE_MAX);
        offer('0, 1'b1);
        offer(SIZE_W'(1), 1'b0);
        settle();
        set_reg(REG_MODE, SIZE_W'(MODE_FIRST));
        set_reg(REG_CAPACITY, SIZE_MAX);
        offer(SIZE_MAX, 1'b1);
        offer(SIZE_W'(65536), 1'b0);

        goal = items_sent + RANDOM_GOAL;
        phase = 0;
        while (items_sent < goal)
        begin
            settle();
            settings_used++;
            if (phase == 3) begin
                fill_table(MODE_NEXT, SIZE_W'(1));
            end
            else if (phase == 9) begin
                fill_table(MODE_BEST, CAP_RESET);
            end
            else begin
                case ($urandom_range(0, 9))
                    0:       cap = '0;
                    1:       cap = SIZE_W'(1);
                    2:       cap = SIZE_MAX;
                    3, 4:    cap = SIZE_W'($urandom_range(2, SIZE_MAX));
                    default: cap = CAP_RESET;
                endcase
                set_reg(REG_MODE, (phase < 4) ? SIZE_W'(phase) : SIZE_W'($urandom_range(0, 3)));
                set_reg(REG_CAPACITY, cap);
                if (phase == 2 || phase == 7) begin
                    hold_request = 1;
                    wait (holding);
                end
                runs = $urandom_range(2, 6);
                for (int r = 0; r < runs; r++) begin
                    span = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 140)
                                                      : $urandom_range(1, 30);
                    for (int k = 0; k < span; k++) begin
                        offer(pick_size(ledger.capacity),
                              (k == 0) ? ($urandom_range(0, 9) != 0)
                                       : ($urandom_range(0, 49) == 0));
                    end
                end
            end
            phase++;
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (ledger.awaiting.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Summary: %0d items over %0d register settings, %0d long output hold-offs.",
                 items_sent, settings_used, holds_done);
        $display("Results seen: %0d existing bin, %0d new bin, %0d table full, %0d oversize.",
                 ledger.seen[ST_EXISTING], ledger.seen[ST_NEW], ledger.seen[ST_FULL],
                 ledger.seen[ST_OVERSIZE]);
        if (ledger.errors == 0 && ledger.awaiting.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
